// ===== rtl/ffd_pkg.sv =====
// Shared types and constants of the floppy flux data separator.
// No dependencies; imported by the interfaces, the top level and the checker.
`default_nettype none

package ffd_pkg;

  // Field and datapath widths
  localparam int unsigned FLUX_W  = 16;
  localparam int unsigned TIME_W  = 18;
  localparam int unsigned CELL_W  = 12;
  localparam int unsigned PHASE_W = 18;
  localparam int unsigned QUO_W   = 6;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned SYM_W   = 2;

  // Bit cell limits, ns
  localparam logic [CELL_W-1:0] CELL_CENTRE = 12'd2000;
  localparam logic [CELL_W-1:0] CELL_MIN    = 12'd1800;
  localparam logic [CELL_W-1:0] CELL_MAX    = 12'd2200;

  // Loop gain divisor and its in-sync multiples (10 * cells)
  localparam logic [CELL_W-1:0] GAIN_DIV    = 12'd10;
  localparam logic [CELL_W-1:0] GAIN_DIV_2C = 12'd20;
  localparam logic [CELL_W-1:0] GAIN_DIV_3C = 12'd30;
  localparam logic [CELL_W-1:0] GAIN_DIV_4C = 12'd40;

  // Clocked-zero thresholds
  localparam logic [QUO_W-1:0] SYNC_MIN    = 6'd1;
  localparam logic [QUO_W-1:0] SYNC_MAX    = 6'd3;
  localparam logic [QUO_W-1:0] LONG_MIN    = 6'd4;
  localparam logic [QUO_W-1:0] ZEROS_OFS   = 6'd3;
  localparam logic [QUO_W-1:0] CHUNK_ZEROS = 6'd4;

  // MFM symbol codes
  localparam logic [SYM_W-1:0] SYM_01   = 2'd0;
  localparam logic [SYM_W-1:0] SYM_001  = 2'd1;
  localparam logic [SYM_W-1:0] SYM_0001 = 2'd2;
  localparam logic [SYM_W-1:0] SYM_0000 = 2'd3;

  typedef enum logic [9:0] {
    S_IDLE  = 10'b00_0000_0001,
    S_CHECK = 10'b00_0000_0010,
    S_DIV1  = 10'b00_0000_0100,
    S_RESID = 10'b00_0000_1000,
    S_SEL   = 10'b00_0001_0000,
    S_DIV2  = 10'b00_0010_0000,
    S_UPD   = 10'b00_0100_0000,
    S_PREP  = 10'b00_1000_0000,
    S_CHUNK = 10'b01_0000_0000,
    S_CLOSE = 10'b10_0000_0000
  } ffd_state_e;

endpackage

`default_nettype wire

// ===== rtl/ffd_intf.sv =====
// Valid/ready channel interfaces: flux interval requests in, MFM symbols out.
// Depends on ffd_pkg for field widths.
`default_nettype none

interface ffd_flux_if
  import ffd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [FLUX_W-1:0] flux_ns;
  logic              at_index;

  modport source (output valid, output flux_ns, output at_index, input ready);
  modport sink   (input valid, input flux_ns, input at_index, output ready);
endinterface

interface ffd_sym_if
  import ffd_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [SYM_W-1:0]  symbol;
  logic [TIME_W-1:0] real_time_ns;
  logic [TIME_W-1:0] pll_time_ns;
  logic              index_mark;
  logic              last;

  modport source (output valid, output symbol, output real_time_ns, output pll_time_ns,
                  output index_mark, output last, input ready);
  modport sink   (input valid, input symbol, input real_time_ns, input pll_time_ns,
                  input index_mark, input last, output ready);
endinterface

`default_nettype wire

// ===== rtl/floppy_flux_dpll_mfm_splitter.sv =====
// Floppy data separator: digital PLL turning flux intervals into MFM symbols.
// Depends on ffd_pkg and the channel interfaces in ffd_intf.sv.
`default_nettype none

// One flux request is taken at a time. Intervals that leave the phase below
// half a cell are only accumulated. Otherwise a short symbol (01, 001, 0001)
// is registered after two passes of a 6-step shift-subtract divider (clocked
// zeros, then the period correction) plus sequencing. With tracking off the
// second pass and the period update are skipped. A long gap first strips the
// closing 01, then emits one 0000 chunk per cycle and a closing 01; output
// stalls hold the sequencer. The output register lets the next request be
// taken while the last symbol still waits downstream. The pll_enabled
// register may be written only while the block is idle.
module floppy_flux_dpll_mfm_splitter
  import ffd_pkg::*;
(
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   cfg_we_i,
  input  wire logic   cfg_wdata_i,
  ffd_flux_if.sink    flux_i,
  ffd_sym_if.source   sym_o
);

  ffd_state_e state_q, state_d;

  // architectural state
  logic                      pll_en_q;
  logic [CELL_W-1:0]         cell_q, cell_d;
  logic signed [PHASE_W-1:0] phase_q, phase_d;
  logic [TIME_W-1:0]         real_q, real_d;
  logic                      idx_q, idx_d;

  // working registers
  logic [TIME_W-1:0]         pll_q, pll_d;
  logic signed [CELL_W:0]    resid_q, resid_d;
  logic [QUO_W-1:0]          clocked_q, clocked_d;
  logic [QUO_W-1:0]          zeros_q, zeros_d;
  logic                      neg_q, neg_d;

  // shared divider
  logic [PHASE_W-1:0]        rem_q, rem_d;
  logic [CELL_W-1:0]         dsr_q, dsr_d;
  logic [QUO_W-1:0]          quo_q, quo_d;
  logic [CNT_W-1:0]          cnt_q, cnt_d;

  // output register
  logic                      ov_q, ov_d;
  logic [SYM_W-1:0]          osym_q, osym_d;
  logic [TIME_W-1:0]         oreal_q, oreal_d;
  logic [TIME_W-1:0]         opll_q, opll_d;
  logic                      oidx_q, oidx_d;
  logic                      olast_q, olast_d;
  logic                      out_load;
  logic                      out_free;

  // datapath terms
  logic [CELL_W-1:0]         half;
  logic signed [PHASE_W-1:0] half_ext;
  logic signed [PHASE_W-1:0] phase_sum;
  logic [PHASE_W-1:0]        dsr_shift;
  logic [PHASE_W:0]          div_diff;
  logic                      div_take;
  logic signed [CELL_W:0]    resid_new;
  logic [CELL_W:0]           resid_mag;
  logic signed [CELL_W:0]    ctr_diff;
  logic [CELL_W:0]           ctr_mag;
  logic signed [QUO_W:0]     delta;
  logic signed [CELL_W+1:0]  cell_sum;
  logic signed [CELL_W:0]    newp;
  logic signed [PHASE_W-1:0] newp_ext;
  logic [TIME_W-1:0]         two_c;
  logic [TIME_W-1:0]         four_c;
  logic [SYM_W-1:0]          short_sym;

  assign flux_i.ready       = (state_q == S_IDLE);
  assign sym_o.valid        = ov_q;
  assign sym_o.symbol       = osym_q;
  assign sym_o.real_time_ns = oreal_q;
  assign sym_o.pll_time_ns  = opll_q;
  assign sym_o.index_mark   = oidx_q;
  assign sym_o.last         = olast_q;

  assign out_free = ~ov_q | sym_o.ready;

  assign half      = {1'b0, cell_q[CELL_W-1:1]};
  assign half_ext  = $signed({{(PHASE_W-CELL_W){1'b0}}, half});
  assign phase_sum = phase_q + $signed({{(PHASE_W-FLUX_W){1'b0}}, flux_i.flux_ns});

  // one restoring step: quotient bits MSB first, cnt_q is the bit weight
  assign dsr_shift = {{(PHASE_W-CELL_W){1'b0}}, dsr_q} << cnt_q;
  assign div_diff  = {1'b0, rem_q} - {1'b0, dsr_shift};
  assign div_take  = ~div_diff[PHASE_W];

  // leftover phase after removing (clocked + 1) cells: rem + half - cell
  assign resid_new = $signed({1'b0, rem_q[CELL_W-1:0]}) + $signed({1'b0, half})
                   - $signed({1'b0, cell_q});
  assign resid_mag = resid_q[CELL_W] ? CELL_W'(0) - resid_q : resid_q;
  assign ctr_diff  = $signed({1'b0, CELL_CENTRE}) - $signed({1'b0, cell_q});
  assign ctr_mag   = ctr_diff[CELL_W] ? CELL_W'(0) - ctr_diff : ctr_diff;

  assign delta    = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
  assign cell_sum = $signed({2'b00, cell_q}) + delta;

  // halve toward zero
  assign newp     = (resid_q + $signed({{CELL_W{1'b0}}, resid_q[CELL_W]})) >>> 1;
  assign newp_ext = {{(PHASE_W-CELL_W-1){newp[CELL_W]}}, newp};

  assign two_c  = {{(TIME_W-CELL_W-1){1'b0}}, cell_q, 1'b0};
  assign four_c = {{(TIME_W-CELL_W-2){1'b0}}, cell_q, 2'b00};

  always_comb begin
    case (clocked_q[1:0])
      2'd2:    short_sym = SYM_001;
      2'd3:    short_sym = SYM_0001;
      default: short_sym = SYM_01;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    cell_d    = cell_q;
    phase_d   = phase_q;
    real_d    = real_q;
    idx_d     = idx_q;
    pll_d     = pll_q;
    resid_d   = resid_q;
    clocked_d = clocked_q;
    zeros_d   = zeros_q;
    neg_d     = neg_q;
    rem_d     = rem_q;
    dsr_d     = dsr_q;
    quo_d     = quo_q;
    cnt_d     = cnt_q;
    out_load  = 1'b0;
    osym_d    = osym_q;
    oreal_d   = oreal_q;
    opll_d    = opll_q;
    oidx_d    = oidx_q;
    olast_d   = olast_q;

    unique case (state_q)
      S_IDLE: begin
        if (flux_i.valid) begin
          phase_d = phase_sum;
          real_d  = real_q + {{(TIME_W-FLUX_W){1'b0}}, flux_i.flux_ns};
          idx_d   = idx_q | flux_i.at_index;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (phase_q < half_ext) begin
          state_d = S_IDLE;
        end else begin
          rem_d   = PHASE_W'(phase_q - half_ext);
          dsr_d   = cell_q;
          quo_d   = '0;
          cnt_d   = CNT_W'(QUO_W - 1);
          state_d = S_DIV1;
        end
      end
      S_DIV1, S_DIV2: begin
        if (div_take) rem_d = div_diff[PHASE_W-1:0];
        quo_d = {quo_q[QUO_W-2:0], div_take};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) state_d = (state_q == S_DIV1) ? S_RESID : S_UPD;
      end
      S_RESID: begin
        clocked_d = quo_q;
        resid_d   = resid_new;
        state_d   = S_SEL;
      end
      S_SEL: begin
        quo_d = '0;
        cnt_d = CNT_W'(QUO_W - 1);
        if (!pll_en_q) begin
          phase_d = '0;
          pll_d   = real_q;
          state_d = S_PREP;
        end else if (clocked_q >= SYNC_MIN && clocked_q <= SYNC_MAX) begin
          // in sync: tenth of the per-cell phase error
          rem_d = {{(PHASE_W-CELL_W-1){1'b0}}, resid_mag};
          neg_d = resid_q[CELL_W];
          case (clocked_q[1:0])
            2'd1:    dsr_d = GAIN_DIV_2C;
            2'd2:    dsr_d = GAIN_DIV_3C;
            default: dsr_d = GAIN_DIV_4C;
          endcase
          state_d = S_DIV2;
        end else begin
          // out of sync: pull a tenth of the way to centre
          rem_d   = {{(PHASE_W-CELL_W-1){1'b0}}, ctr_mag};
          neg_d   = ctr_diff[CELL_W];
          dsr_d   = GAIN_DIV;
          state_d = S_DIV2;
        end
      end
      S_UPD: begin
        if (cell_sum < $signed({2'b00, CELL_MIN})) begin
          cell_d = CELL_MIN;
        end else if (cell_sum > $signed({2'b00, CELL_MAX})) begin
          cell_d = CELL_MAX;
        end else begin
          cell_d = cell_sum[CELL_W-1:0];
        end
        pll_d   = TIME_W'(phase_q - newp_ext);
        phase_d = newp_ext;
        state_d = S_PREP;
      end
      S_PREP: begin
        if (clocked_q >= LONG_MIN) begin
          // strip the closing 01 from both times
          real_d  = (real_q > two_c) ? real_q - two_c : '0;
          pll_d   = (pll_q > two_c) ? pll_q - two_c : '0;
          zeros_d = clocked_q - ZEROS_OFS;
          state_d = S_CHUNK;
        end else if (out_free) begin
          out_load = 1'b1;
          osym_d   = short_sym;
          oreal_d  = real_q;
          opll_d   = pll_q;
          oidx_d   = idx_q;
          olast_d  = 1'b1;
          idx_d    = 1'b0;
          real_d   = '0;
          state_d  = S_IDLE;
        end
      end
      S_CHUNK: begin
        if (out_free) begin
          out_load = 1'b1;
          osym_d   = SYM_0000;
          oreal_d  = (real_q > four_c) ? four_c : real_q;
          opll_d   = (pll_q > four_c) ? four_c : pll_q;
          oidx_d   = idx_q;
          olast_d  = 1'b0;
          idx_d    = 1'b0;
          real_d   = real_q - oreal_d;
          pll_d    = pll_q - opll_d;
          zeros_d  = zeros_q - CHUNK_ZEROS;
          if (zeros_q <= CHUNK_ZEROS) state_d = S_CLOSE;
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          out_load = 1'b1;
          osym_d   = SYM_01;
          oreal_d  = two_c;
          opll_d   = two_c;
          oidx_d   = idx_q;
          olast_d  = 1'b1;
          idx_d    = 1'b0;
          real_d   = '0;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign ov_d = out_load | (ov_q & ~sym_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      pll_en_q <= 1'b1;
      cell_q   <= CELL_CENTRE;
      phase_q  <= '0;
      real_q   <= '0;
      idx_q    <= 1'b0;
      ov_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) pll_en_q <= cfg_wdata_i;
      cell_q  <= cell_d;
      phase_q <= phase_d;
      real_q  <= real_d;
      idx_q   <= idx_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pll_q     <= pll_d;
    resid_q   <= resid_d;
    clocked_q <= clocked_d;
    zeros_q   <= zeros_d;
    neg_q     <= neg_d;
    rem_q     <= rem_d;
    dsr_q     <= dsr_d;
    quo_q     <= quo_d;
    cnt_q     <= cnt_d;
    osym_q    <= osym_d;
    oreal_q   <= oreal_d;
    opll_q    <= opll_d;
    oidx_q    <= oidx_d;
    olast_q   <= olast_d;
  end

endmodule

`default_nettype wire

// ===== rtl/ffd_chk.sv =====
// Port-level checker for the flux data separator, bound to the top level.
// Depends on ffd_pkg for symbol codes and cell limits.
`default_nettype none

module ffd_chk
  import ffd_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              in_valid,
  input wire logic              in_ready,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire logic [SYM_W-1:0]  out_symbol,
  input wire logic [TIME_W-1:0] out_real,
  input wire logic [TIME_W-1:0] out_pll,
  input wire logic              out_index,
  input wire logic              out_last
);

  localparam logic [TIME_W-1:0] CHUNK_MAX = TIME_W'(4 * CELL_MAX);

  // stalled symbol holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_symbol) && $stable(out_real)
      && $stable(out_pll) && $stable(out_index) && $stable(out_last))
    else $error("stalled symbol changed");

  // one request in flight
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // only 0000 chunks are non-final
  a_last_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (out_last == (out_symbol != SYM_0000)))
    else $error("last flag does not match symbol");

  // a chunk covers at most four cells
  a_chunk_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_symbol == SYM_0000 |-> out_real <= CHUNK_MAX && out_pll <= CHUNK_MAX)
    else $error("0000 chunk too long");

endmodule

bind floppy_flux_dpll_mfm_splitter ffd_chk u_ffd_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (flux_i.valid),
  .in_ready   (flux_i.ready),
  .out_valid  (sym_o.valid),
  .out_ready  (sym_o.ready),
  .out_symbol (sym_o.symbol),
  .out_real   (sym_o.real_time_ns),
  .out_pll    (sym_o.pll_time_ns),
  .out_index  (sym_o.index_mark),
  .out_last   (sym_o.last)
);

`default_nettype wire
